// ===== hdl/ptcp_pkg.sv =====
// Shared types and constants for the point-to-triangle closest point block.
`timescale 1ns / 1ps

package ptcp_pkg;

    localparam int COORD_BITS = 16;
    localparam int LERP_BITS  = 16;

    typedef logic signed [COORD_BITS-1:0] crd_t;
    typedef logic signed [COORD_BITS:0]   dif_t;

    typedef enum logic [2:0] {
        REG_VERT_A  = 3'd0,
        REG_VERT_B  = 3'd1,
        REG_EDGE_AB = 3'd2,
        REG_VERT_C  = 3'd3,
        REG_EDGE_AC = 3'd4,
        REG_EDGE_BC = 3'd5,
        REG_FACE    = 3'd6
    } region_t;

    typedef struct packed {
        crd_t p_x;
        crd_t p_y;
        crd_t p_z;
        crd_t a_x;
        crd_t a_y;
        crd_t a_z;
        crd_t b_x;
        crd_t b_y;
        crd_t b_z;
        crd_t c_x;
        crd_t c_y;
        crd_t c_z;
    } in_t;

    typedef struct packed {
        crd_t    q_x;
        crd_t    q_y;
        crd_t    q_z;
        region_t region;
    } out_t;

    // triangle geometry carried down the dot-product stages
    typedef struct packed {
        crd_t [2:0] a;
        crd_t [2:0] b;
        crd_t [2:0] c;
        dif_t [2:0] ab;
        dif_t [2:0] ac;
        dif_t [2:0] bc;
    } geo_t;

    // what the interpolation tail needs once the region is known
    typedef struct packed {
        region_t    region;
        crd_t [2:0] base;
        dif_t [2:0] e1;
        dif_t [2:0] e2;
    } tail_t;

endpackage

// ===== hdl/point_triangle_closest_point.sv =====
// Closest point on a 3D triangle to a query point: top level, fully pipelined.
//
// Input channel s_valid/s_ready/s_data carries one query: point P and vertices
// A, B, C, signed fixed point. Result channel m_valid/m_ready/m_data carries
// the closest point Q and the Voronoi region code.
// From the accepting edge to m_valid a query passes eight stages of
// differences, dot products, split 36x36 products, region tests and divider
// set-up, sixteen restoring divider stages (one quotient bit each, both
// barycentric weights side by side), one interpolation multiply stage and
// the output register.
// Throughput is one item per cycle (one-bit-per-stage divider) unless m_ready stalls.
// Results keep the order of the queries.
// Reset (aresetn low at a rising edge) empties the pipeline, the output
// register and the skid register; s_ready is high after reset.
// When the receiver stalls, the pipeline moves on once more into the skid
// register, then holds every stage and drops s_ready until m_ready returns.
// A degenerate triangle (zero divisor) gives the region's first vertex.
`timescale 1ns / 1ps

module point_triangle_closest_point (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ptcp_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output ptcp_pkg::out_t  m_data
);

    localparam int CW   = ptcp_pkg::COORD_BITS;
    localparam int LB   = ptcp_pkg::LERP_BITS;
    localparam int DFW  = CW + 1;          // coordinate difference
    localparam int PRW  = 2 * DFW;         // difference product
    localparam int DW   = PRW + 2;         // dot product
    localparam int HW   = DW / 2;          // split point of the wide product
    localparam int LW   = DW - HW;
    localparam int PPW  = 2 * LW + 2;      // partial product
    localparam int MW   = 2 * DW;          // full product
    localparam int VW   = MW + 4;          // va/vb/vc, divisors, remainders
    localparam int FW   = LB + 1;          // fraction incl. the value one
    localparam int PFW  = FW + 1 + DFW;    // fraction times difference
    localparam int SUMW = PFW + 1;
    localparam int SHW  = SUMW - LB;
    localparam int QW   = SHW + 1;
    localparam int ND   = LB;              // divider stages

    localparam logic signed [QW-1:0] QMAX = QW'((2 ** (CW - 1)) - 1);
    localparam logic signed [QW-1:0] QMIN = -QMAX - QW'(1);

    localparam int MA [6] = '{0, 2, 4, 0, 2, 4};
    localparam int MB [6] = '{3, 1, 1, 5, 5, 3};

    logic sk_v_reg;

    logic en;
    assign en      = 1'b1 & ~sk_v_reg;
    assign s_ready = en;

    // ---------------- stage 1: differences ----------------
    ptcp_pkg::geo_t             geo1_reg, geo1_next;
    ptcp_pkg::dif_t [2:0]       ap1_reg, bp1_reg, cp1_reg;
    ptcp_pkg::dif_t [2:0]       ap1_next, bp1_next, cp1_next;
    logic                       v1_reg;
    ptcp_pkg::crd_t [2:0]       pin, ain, bin, cin;

    always_comb begin
        pin = {s_data.p_z, s_data.p_y, s_data.p_x};
        ain = {s_data.a_z, s_data.a_y, s_data.a_x};
        bin = {s_data.b_z, s_data.b_y, s_data.b_x};
        cin = {s_data.c_z, s_data.c_y, s_data.c_x};
        geo1_next.a = ain;
        geo1_next.b = bin;
        geo1_next.c = cin;
        for (int i = 0; i < 3; i++) begin
            geo1_next.ab[i] = DFW'($signed(bin[i])) - DFW'($signed(ain[i]));
            geo1_next.ac[i] = DFW'($signed(cin[i])) - DFW'($signed(ain[i]));
            geo1_next.bc[i] = DFW'($signed(cin[i])) - DFW'($signed(bin[i]));
            ap1_next[i]     = DFW'($signed(pin[i])) - DFW'($signed(ain[i]));
            bp1_next[i]     = DFW'($signed(pin[i])) - DFW'($signed(bin[i]));
            cp1_next[i]     = DFW'($signed(pin[i])) - DFW'($signed(cin[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo1_reg <= geo1_next;
            ap1_reg  <= ap1_next;
            bp1_reg  <= bp1_next;
            cp1_reg  <= cp1_next;
        end
    end

    // ---------------- stage 2: eighteen products ----------------
    ptcp_pkg::geo_t          geo2_reg;
    logic signed [PRW-1:0]   pr2_reg  [18];
    logic signed [PRW-1:0]   pr2_next [18];
    logic                    v2_reg;
    ptcp_pkg::dif_t [2:0]    du [6];
    ptcp_pkg::dif_t [2:0]    dv [6];

    always_comb begin
        du = '{geo1_reg.ab, geo1_reg.ac, geo1_reg.ab, geo1_reg.ac, geo1_reg.ab, geo1_reg.ac};
        dv = '{ap1_reg, ap1_reg, bp1_reg, bp1_reg, cp1_reg, cp1_reg};
        for (int k = 0; k < 6; k++) begin
            for (int i = 0; i < 3; i++) begin
                pr2_next[3*k+i] = PRW'($signed(du[k][i])) * PRW'($signed(dv[k][i]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo2_reg <= geo1_reg;
            pr2_reg  <= pr2_next;
        end
    end

    // ---------------- stage 3: dot products d1..d6 ----------------
    ptcp_pkg::geo_t         geo3_reg;
    logic signed [DW-1:0]   d3_reg  [6];
    logic signed [DW-1:0]   d3_next [6];
    logic                   v3_reg;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            d3_next[k] = DW'(pr2_reg[3*k]) + DW'(pr2_reg[3*k+1]) + DW'(pr2_reg[3*k+2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo3_reg <= geo2_reg;
            d3_reg   <= d3_next;
        end
    end

    // ---------------- stage 4: partial products of the six wide products ----
    ptcp_pkg::geo_t         geo4_reg;
    logic signed [DW-1:0]   d4_reg [6];
    logic signed [PPW-1:0]  pp4_reg  [6][4];
    logic signed [PPW-1:0]  pp4_next [6][4];
    logic                   v4_reg;

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            pp4_next[j][0] = PPW'($signed(d3_reg[MA[j]][DW-1:HW]))
                           * PPW'($signed(d3_reg[MB[j]][DW-1:HW]));
            pp4_next[j][1] = PPW'($signed(d3_reg[MA[j]][DW-1:HW]))
                           * PPW'($signed({1'b0, d3_reg[MB[j]][HW-1:0]}));
            pp4_next[j][2] = PPW'($signed({1'b0, d3_reg[MA[j]][HW-1:0]}))
                           * PPW'($signed(d3_reg[MB[j]][DW-1:HW]));
            pp4_next[j][3] = PPW'($signed({1'b0, d3_reg[MA[j]][HW-1:0]}))
                           * PPW'($signed({1'b0, d3_reg[MB[j]][HW-1:0]}));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo4_reg <= geo3_reg;
            d4_reg   <= d3_reg;
            pp4_reg  <= pp4_next;
        end
    end

    // ---------------- stage 5: recombine the wide products ----------------
    ptcp_pkg::geo_t         geo5_reg;
    logic signed [DW-1:0]   d5_reg [6];
    logic signed [MW-1:0]   m5_reg  [6];
    logic signed [MW-1:0]   m5_next [6];
    logic                   v5_reg;

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            m5_next[j] = (MW'(pp4_reg[j][0]) <<< (2 * HW))
                       + (MW'(pp4_reg[j][1]) <<< HW)
                       + (MW'(pp4_reg[j][2]) <<< HW)
                       + MW'(pp4_reg[j][3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo5_reg <= geo4_reg;
            d5_reg   <= d4_reg;
            m5_reg   <= m5_next;
        end
    end

    // ---------------- stage 6: va, vb, vc ----------------
    ptcp_pkg::geo_t         geo6_reg;
    logic signed [DW-1:0]   d6_reg [6];
    logic signed [VW-1:0]   va6_reg, vb6_reg, vc6_reg;
    logic                   v6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            geo6_reg <= geo5_reg;
            d6_reg   <= d5_reg;
            vc6_reg  <= VW'(m5_reg[0]) - VW'(m5_reg[1]);
            vb6_reg  <= VW'(m5_reg[2]) - VW'(m5_reg[3]);
            va6_reg  <= VW'(m5_reg[4]) - VW'(m5_reg[5]);
        end
    end

    // ---------------- stage 7: region tests, pick numerators and divisor ----
    ptcp_pkg::tail_t        tl7_reg, tl7_next;
    logic signed [VW-1:0]   n17_reg, n27_reg, den7_reg;
    logic signed [VW-1:0]   n17_next, n27_next, den7_next, den_sel;
    logic signed [DW:0]     d43, d56;
    logic                   v7_reg;

    always_comb begin
        d43       = (DW+1)'(d6_reg[3]) - (DW+1)'(d6_reg[2]);
        d56       = (DW+1)'(d6_reg[4]) - (DW+1)'(d6_reg[5]);
        tl7_next.base = geo6_reg.a;
        tl7_next.e1   = '0;
        tl7_next.e2   = '0;
        n17_next  = '0;
        n27_next  = '0;
        den_sel   = '0;
        priority if (d6_reg[0] <= 0 && d6_reg[1] <= 0) begin
            tl7_next.region = ptcp_pkg::REG_VERT_A;
        end else if (d6_reg[2] >= 0 && d43 <= 0) begin
            tl7_next.region = ptcp_pkg::REG_VERT_B;
            tl7_next.base   = geo6_reg.b;
        end else if (vc6_reg <= 0 && d6_reg[0] >= 0 && d6_reg[2] <= 0) begin
            tl7_next.region = ptcp_pkg::REG_EDGE_AB;
            den_sel         = VW'(d6_reg[0]) - VW'(d6_reg[2]);
            n17_next        = VW'(d6_reg[0]);
            tl7_next.e1     = geo6_reg.ab;
        end else if (d6_reg[5] >= 0 && d56 <= 0) begin
            tl7_next.region = ptcp_pkg::REG_VERT_C;
            tl7_next.base   = geo6_reg.c;
        end else if (vb6_reg <= 0 && d6_reg[1] >= 0 && d6_reg[5] <= 0) begin
            tl7_next.region = ptcp_pkg::REG_EDGE_AC;
            den_sel         = VW'(d6_reg[1]) - VW'(d6_reg[5]);
            n17_next        = VW'(d6_reg[1]);
            tl7_next.e1     = geo6_reg.ac;
        end else if (va6_reg <= 0 && d43 >= 0 && d56 >= 0) begin
            tl7_next.region = ptcp_pkg::REG_EDGE_BC;
            tl7_next.base   = geo6_reg.b;
            den_sel         = VW'(d43) + VW'(d56);
            n17_next        = VW'(d43);
            tl7_next.e1     = geo6_reg.bc;
        end else begin
            tl7_next.region = ptcp_pkg::REG_FACE;
            den_sel         = va6_reg + vb6_reg + vc6_reg;
            n17_next        = vb6_reg;
            n27_next        = vc6_reg;
            tl7_next.e1     = geo6_reg.ab;
            tl7_next.e2     = geo6_reg.ac;
        end
        // vertex regions and a zero divisor both end up as weight zero on the base
        if (den_sel == 0) begin
            den7_next = VW'(1);
            n17_next  = '0;
            n27_next  = '0;
        end else begin
            den7_next = den_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tl7_reg  <= tl7_next;
            n17_reg  <= n17_next;
            n27_reg  <= n27_next;
            den7_reg <= den7_next;
        end
    end

    // ---------------- stage 8 and divider: index 0 is set-up, k+1 after bit k ----
    ptcp_pkg::tail_t        tl_reg [ND+1];
    logic [VW-1:0]          r1_reg [ND+1];
    logic [VW-1:0]          r2_reg [ND+1];
    logic [VW-1:0]          dv_reg [ND+1];
    logic [LB-1:0]          q1_reg [ND+1];
    logic [LB-1:0]          q2_reg [ND+1];
    logic                   z1_reg [ND+1];
    logic                   z2_reg [ND+1];
    logic                   s1_reg [ND+1];
    logic                   s2_reg [ND+1];
    logic                   vd_reg [ND+1];

    logic [VW-1:0]          r1_abs, r2_abs, dv_abs;

    always_comb begin
        r1_abs = n17_reg[VW-1]  ? VW'(-n17_reg)  : VW'(n17_reg);
        r2_abs = n27_reg[VW-1]  ? VW'(-n27_reg)  : VW'(n27_reg);
        dv_abs = den7_reg[VW-1] ? VW'(-den7_reg) : VW'(den7_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tl_reg[0] <= tl7_reg;
            r1_reg[0] <= r1_abs;
            r2_reg[0] <= r2_abs;
            dv_reg[0] <= dv_abs;
            q1_reg[0] <= '0;
            q2_reg[0] <= '0;
            z1_reg[0] <= (n17_reg == 0) || (n17_reg[VW-1] != den7_reg[VW-1]);
            z2_reg[0] <= (n27_reg == 0) || (n27_reg[VW-1] != den7_reg[VW-1]);
            s1_reg[0] <= r1_abs >= dv_abs;
            s2_reg[0] <= r2_abs >= dv_abs;
        end
    end

    for (genvar k = 0; k < ND; k++) begin : g_div
        logic [VW:0] t1, t2;
        logic        b1, b2;

        always_comb begin
            t1 = {r1_reg[k], 1'b0};
            t2 = {r2_reg[k], 1'b0};
            b1 = t1 >= {1'b0, dv_reg[k]};
            b2 = t2 >= {1'b0, dv_reg[k]};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                tl_reg[k+1] <= tl_reg[k];
                dv_reg[k+1] <= dv_reg[k];
                r1_reg[k+1] <= b1 ? VW'(t1 - {1'b0, dv_reg[k]}) : t1[VW-1:0];
                r2_reg[k+1] <= b2 ? VW'(t2 - {1'b0, dv_reg[k]}) : t2[VW-1:0];
                q1_reg[k+1] <= {q1_reg[k][LB-2:0], b1};
                q2_reg[k+1] <= {q2_reg[k][LB-2:0], b2};
                z1_reg[k+1] <= z1_reg[k];
                z2_reg[k+1] <= z2_reg[k];
                s1_reg[k+1] <= s1_reg[k];
                s2_reg[k+1] <= s2_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vd_reg[k+1] <= 1'b0;
            end else if (en) begin
                vd_reg[k+1] <= vd_reg[k];
            end
        end
    end

    // ---------------- interpolation multiply ----------------
    logic [FW-1:0]          f_w, g_w;
    ptcp_pkg::tail_t        tlm_reg;
    logic signed [PFW-1:0]  pf_reg [3];
    logic signed [PFW-1:0]  pg_reg [3];
    logic                   vm_reg;

    always_comb begin
        f_w = z1_reg[ND] ? '0 : (s1_reg[ND] ? FW'(1) << LB : {1'b0, q1_reg[ND]});
        g_w = z2_reg[ND] ? '0 : (s2_reg[ND] ? FW'(1) << LB : {1'b0, q2_reg[ND]});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tlm_reg <= tl_reg[ND];
            for (int i = 0; i < 3; i++) begin
                pf_reg[i] <= PFW'($signed({1'b0, f_w})) * PFW'($signed(tl_reg[ND].e1[i]));
                pg_reg[i] <= PFW'($signed({1'b0, g_w})) * PFW'($signed(tl_reg[ND].e2[i]));
            end
        end
    end

    // ---------------- final add, floor shift, saturation ----------------
    ptcp_pkg::out_t         res;
    ptcp_pkg::crd_t [2:0]   qv;
    logic signed [SUMW-1:0] sum_w [3];
    logic signed [QW-1:0]   qs_w  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum_w[i] = SUMW'(pf_reg[i]) + SUMW'(pg_reg[i]);
            qs_w[i]  = QW'($signed(tlm_reg.base[i])) + QW'($signed(sum_w[i][SUMW-1:LB]));
            if (qs_w[i] > QMAX) begin
                qv[i] = CW'(QMAX);
            end else if (qs_w[i] < QMIN) begin
                qv[i] = CW'(QMIN);
            end else begin
                qv[i] = CW'(qs_w[i]);
            end
        end
        res.q_x    = qv[0];
        res.q_y    = qv[1];
        res.q_z    = qv[2];
        res.region = tlm_reg.region;
    end

    // ---------------- valid bits of stages 1 to 8 and the multiply ----------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            v7_reg    <= 1'b0;
            vd_reg[0] <= 1'b0;
            vm_reg    <= 1'b0;
        end else if (en) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            v7_reg    <= v6_reg;
            vd_reg[0] <= v7_reg;
            vm_reg    <= vd_reg[ND];
        end
    end

    // ---------------- output register and skid register ----------------
    ptcp_pkg::out_t  out_reg, out_next, sk_reg, sk_next;
    logic            out_v_reg, out_v_next, sk_v_next;

    always_comb begin
        out_next   = out_reg;
        sk_next    = sk_reg;
        out_v_next = out_v_reg;
        sk_v_next  = sk_v_reg;
        if (sk_v_reg) begin
            if (m_ready) begin
                out_next  = sk_reg;
                sk_v_next = 1'b0;
            end
        end else if (vm_reg) begin
            if (!out_v_reg || m_ready) begin
                out_next   = res;
                out_v_next = 1'b1;
            end else begin
                sk_next   = res;
                sk_v_next = 1'b1;
            end
        end else if (m_ready) begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
        end else begin
            out_v_reg <= out_v_next;
            sk_v_reg  <= sk_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        sk_reg  <= sk_next;
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

// ===== hdl/ptcp_checker.sv =====
// Port-level assertions for the closest point block, bound to its top level.
`timescale 1ns / 1ps

module ptcp_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input ptcp_pkg::out_t  m_data
);

    // a held result keeps its valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result item changed while stalled");

    // input back-pressure only follows a stalled result
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> $past(m_valid && !m_ready))
        else $error("s_ready low without a stalled result");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with an empty output");

    a_reset_clear: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("m_valid high after reset");

endmodule

bind point_triangle_closest_point ptcp_checker u_ptcp_checker (.*);
